// ===== hdl/tis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tis_pkg;

	localparam int MaxSegmentsDefault = 64;
	localparam int CoordW = 16;
	localparam int ValueW = 32;
	localparam int StepW = 31;
	localparam int DiffW = 33;
	localparam int QuoW = 34;
	localparam int ProdW = 50;

	localparam logic [0:0] RegOrigin = 1'b0;
	localparam logic [0:0] RegStep = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_SPREAD,
		ST_FIRST_DIV,
		ST_FIRST,
		ST_COUNT_DIV,
		ST_LEVEL,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_EMIT
	} tis_state_t;

	// divider request and result
	typedef struct packed {
		logic start;
		logic [ProdW-1:0] num;
		logic [DiffW-1:0] den;
	} tis_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [ProdW-1:0] quo;
		logic [DiffW-1:0] rem;
	} tis_div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/triangle_isoline_segments.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Contour segments for one triangle. A triangle beat is taken when the block is
// idle; values are sorted, and every level origin + k*step strictly between the
// lowest and highest value yields one segment, at most MAX_SEGMENTS, in
// ascending order; none at all if 1000 times the spread is below the step.
// All divisions share one radix-2 divider of 50 steps. Setup sorts, then
// divides once for the first level and once for the level count; each segment
// takes four such divisions, each after a multiply and a start state. The block
// accepts no triangle until its last segment beat has left the output register.
module triangle_isoline_segments
	import tis_pkg::*;
#(
	parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// a_x, a_y, a_value, b_x, b_y, b_value, c_x, c_y, c_value
	input wire logic [191:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// start_x, start_y, end_x, end_y
	output logic [63:0] m_tdata,
	output logic m_tlast,
	// truncated
	output logic [0:0] m_tuser
);

	localparam int CntW = $clog2(MAX_SEGMENTS + 1);

	tis_state_t state_q, state_d;

	logic signed [ValueW-1:0] origin_q;
	logic [StepW-1:0] step_q;
	logic signed [CoordW-1:0] px_q [3];
	logic signed [CoordW-1:0] py_q [3];
	logic signed [ValueW-1:0] pv_q [3];
	logic [1:0] sort_cnt_q;
	logic parity_q;
	logic signed [DiffW:0] first_q;
	logic signed [DiffW:0] lev_q;
	logic [CntW-1:0] left_q;
	logic trunc_q;
	logic [1:0] op_q;
	logic signed [DiffW:0] dl_q;
	logic [DiffW-1:0] den_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [CoordW-1:0] res_q [4];
	logic [63:0] out_data_q;
	logic out_last_q;
	logic out_trunc_q;
	logic out_valid_q;

	tis_div_req_t dreq;
	tis_div_rsp_t drsp;

	tis_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [StepW-1:0] step_eff;
	logic signed [DiffW-1:0] spread;
	logic signed [DiffW:0] d_lo;
	logic [DiffW-1:0] d_mag;
	logic [1:0] sj;
	logic [1:0] sa, sb;
	logic signed [CoordW-1:0] cp, cq;
	logic signed [CoordW:0] cdiff;
	logic signed [DiffW:0] sel_dl;
	logic [DiffW-1:0] sel_den;
	logic [ProdW-1:0] prod_mag;
	logic [ProdW:0] round_q;
	logic signed [CoordW:0] coord_new;
	logic signed [DiffW+11:0] spread_k;
	logic [DiffW:0] first_dist;
	logic [ProdW-1:0] k_floor;

	assign step_eff = (step_q == '0) ? StepW'(1) : step_q;
	assign spread = DiffW'(pv_q[2]) - DiffW'(pv_q[0]);
	assign spread_k = (DiffW+12)'(spread) * 45'sd1000;
	assign d_lo = (DiffW+1)'(pv_q[0]) - (DiffW+1)'(origin_q);
	assign d_mag = d_lo[DiffW] ? DiffW'(-d_lo) : DiffW'(d_lo);
	assign first_dist = (DiffW+1)'((DiffW+1)'(pv_q[2]) - first_q - 1);
	assign sj = sort_cnt_q[0] ? 2'd1 : 2'd0;

	// endpoint edge selection for the current level
	always_comb begin
		if (lev_q < (DiffW+1)'(pv_q[1])) begin
			sa = 2'd0;
			sb = 2'd1;
		end else begin
			sa = 2'd1;
			sb = 2'd2;
		end
	end

	// operand pick: op 0,1 short edge x,y; op 2,3 long edge x,y
	always_comb begin
		if (op_q[1]) begin
			cp = op_q[0] ? py_q[0] : px_q[0];
			cq = op_q[0] ? py_q[2] : px_q[2];
			sel_dl = lev_q - (DiffW+1)'(pv_q[0]);
			sel_den = DiffW'(spread);
		end else begin
			cp = op_q[0] ? py_q[sa] : px_q[sa];
			cq = op_q[0] ? py_q[sb] : px_q[sb];
			sel_dl = lev_q - (DiffW+1)'(pv_q[sa]);
			sel_den = DiffW'((DiffW+1)'(pv_q[sb]) - (DiffW+1)'(pv_q[sa]));
		end
		cdiff = (CoordW+1)'(cq) - (CoordW+1)'(cp);
	end

	// rounding: floor((2|num| + den) / 2den) == floor((|num| + den/2 rounding))
	assign prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
	always_comb begin
		round_q = {1'b0, drsp.quo};
		if ({drsp.rem, 1'b0} >= {1'b0, den_q}) round_q = round_q + 1'b1;
		coord_new = prod_q[ProdW-1] ? (CoordW+1)'(cp) - (CoordW+1)'(round_q)
			: (CoordW+1)'(cp) + (CoordW+1)'(round_q);
	end

	assign k_floor = (d_lo[DiffW] && drsp.rem != '0) ? drsp.quo + 1'b1 : drsp.quo;

	// divider requests
	always_comb begin
		dreq = '0;
		case (state_q)
			ST_SPREAD: begin
				dreq.start = !(spread_k < (DiffW+12)'(step_eff));
				dreq.num = ProdW'(d_mag);
				dreq.den = DiffW'(step_eff);
			end
			ST_FIRST: begin
				dreq.start = !(first_q >= (DiffW+1)'(pv_q[2]));
				dreq.num = ProdW'(first_dist);
				dreq.den = DiffW'(step_eff);
			end
			ST_DIV_START: begin
				dreq.start = 1'b1;
				dreq.num = prod_mag;
				dreq.den = den_q;
			end
			default: dreq = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_SORT;
			ST_SORT: if (sort_cnt_q == 2'd3) state_d = ST_SPREAD;
			ST_SPREAD: state_d = dreq.start ? ST_FIRST_DIV : ST_IDLE;
			ST_FIRST_DIV: if (drsp.done) state_d = ST_FIRST;
			ST_FIRST: state_d = dreq.start ? ST_COUNT_DIV : ST_IDLE;
			ST_COUNT_DIV: if (drsp.done) state_d = ST_LEVEL;
			ST_LEVEL: if (!out_valid_q || m_tready) state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: if (drsp.done) state_d = (op_q == 2'd3) ? ST_EMIT : ST_MUL;
			ST_EMIT: state_d = (left_q == CntW'(1)) ? ST_IDLE : ST_LEVEL;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			origin_q <= '0;
			step_q <= StepW'(65536);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= (state_q == ST_IDLE && !s_tready) ? ST_IDLE : state_d;
			if (cfg_we) begin
				if (cfg_index == RegOrigin) origin_q <= cfg_data;
				if (cfg_index == RegStep) step_q <= cfg_data[StepW-1:0];
			end
			if (state_q == ST_EMIT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					px_q[i] <= s_tdata[64*i +: 16];
					py_q[i] <= s_tdata[64*i+16 +: 16];
					pv_q[i] <= s_tdata[64*i+32 +: 32];
				end
				sort_cnt_q <= '0;
				parity_q <= 1'b0;
			end
			ST_SORT: begin
				// compare-and-swap on neighbors, positions 0-1,1-2,0-1,1-2
				sort_cnt_q <= sort_cnt_q + 2'd1;
				if (pv_q[sj] > pv_q[sj+2'd1]) begin
					pv_q[sj] <= pv_q[sj+2'd1];
					pv_q[sj+2'd1] <= pv_q[sj];
					px_q[sj] <= px_q[sj+2'd1];
					px_q[sj+2'd1] <= px_q[sj];
					py_q[sj] <= py_q[sj+2'd1];
					py_q[sj+2'd1] <= py_q[sj];
					parity_q <= !parity_q;
				end
			end
			ST_FIRST_DIV: if (drsp.done) begin
				first_q <= (DiffW+1)'(origin_q) + (d_lo[DiffW]
					? -(DiffW+1)'(k_floor[DiffW:0] - 1'b1) * (DiffW+1)'(step_eff)
					: (DiffW+1)'(k_floor[DiffW:0] + 1'b1) * (DiffW+1)'(step_eff));
			end
			ST_FIRST: lev_q <= first_q;
			ST_COUNT_DIV: if (drsp.done) begin
				trunc_q <= (drsp.quo + 1'b1) > ProdW'(MAX_SEGMENTS);
				left_q <= ((drsp.quo + 1'b1) > ProdW'(MAX_SEGMENTS))
					? CntW'(MAX_SEGMENTS) : CntW'(drsp.quo + 1'b1);
				op_q <= '0;
			end
			ST_MUL: begin
				prod_q <= ProdW'(sel_dl) * ProdW'(cdiff);
				den_q <= sel_den;
			end
			ST_DIV: if (drsp.done) begin
				res_q[op_q] <= coord_new[CoordW-1:0];
				op_q <= op_q + 2'd1;
			end
			ST_EMIT: begin
				out_data_q <= parity_q ? {res_q[3], res_q[2], res_q[1], res_q[0]}
					: {res_q[1], res_q[0], res_q[3], res_q[2]};
				out_last_q <= (left_q == CntW'(1));
				out_trunc_q <= trunc_q;
				left_q <= left_q - CntW'(1);
				lev_q <= lev_q + (DiffW+1)'(step_eff);
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;
	assign m_tuser = out_trunc_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("accept while busy");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!out_valid_q || m_tready)) else $error("overwrite");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider restarted");
`endif

endmodule
`default_nettype wire

// ===== hdl/tis_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tis_divider
	import tis_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire tis_div_req_t req,
	output tis_div_rsp_t rsp
);

	logic [ProdW-1:0] quo_q;
	logic [DiffW:0] rem_q;
	logic [DiffW-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DiffW:0] trial;
	logic ge;

	// one restoring step per cycle, unsigned
	always_comb begin
		trial = {rem_q[DiffW-1:0], quo_q[ProdW-1]};
		ge = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(ProdW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[ProdW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q[DiffW-1:0];

endmodule
`default_nettype wire
